>>> rtl/core/cdts_pkg.sv
// Shared types and constants of the clock drift time sync block.
package cdts_pkg;

	localparam int TIME_BITS_DEF = 64;
	localparam int ARITH_W       = 64;
	localparam int CNT_W         = $clog2(ARITH_W);
	localparam int KIND_W        = 2;
	localparam int STATUS_W      = 3;
	localparam int TPS_W         = 27;
	localparam int DRIFT_W       = 20;
	localparam int AVG_W         = 21;
	localparam int MEAS_W        = 32;
	localparam int MUL_W         = 22;
	localparam int CFG_IDX_W     = 2;

	localparam logic [TPS_W-1:0]   TPS_RST  = TPS_W'(32768);
	localparam logic [DRIFT_W-1:0] MAX_RST  = DRIFT_W'(200);
	localparam logic [DRIFT_W-1:0] TYP_RST  = DRIFT_W'(50);

	// microseconds per second, as a signed multiplier operand
	localparam logic signed [MUL_W-1:0] US_MUL = MUL_W'(1000000);

	typedef enum logic [KIND_W-1:0] {
		KIND_CAPTURE = 2'd0,
		KIND_SET     = 2'd1,
		KIND_QUERY   = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_CAP_IGN  = 3'd1,
		STAT_NO_CAP   = 3'd2,
		STAT_FIRST    = 3'd3,
		STAT_UNUSUAL  = 3'd4,
		STAT_REJECT   = 3'd5,
		STAT_ZERO_INT = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TPS = 2'd0,
		CFG_MAX = 2'd1,
		CFG_TYP = 2'd2
	} cfg_idx_t;

	// which arithmetic pass the shared multiplier/divider is running
	typedef enum logic [1:0] {
		STEP_L = 2'd0,   // local interval: ticks * 1e6 / tps
		STEP_X = 2'd1,   // drift: (L - M) * 1e6 / M
		STEP_Q = 2'd2    // query: dt * (1e6 - avg) / tps
	} step_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EVAL  = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_SIGN  = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_POST  = 8'b0010_0000,
		ST_APPLY = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

endpackage

>>> rtl/core/clock_drift_time_sync.sv
// Clock drift compensated time sync: capture, set and query engine.
// One transaction at a time. Captures, sets without capture, first syncs and
//   zero-interval sets skip the arithmetic; a bit-serial multiplier and a
//   restoring divider (one bit per cycle) run once for a query and twice for a
//   drift measurement.
// Reset (arst_n low, asynchronous): config to 32768 tps / 200 / 50 ppm, no capture
//   pending, sync pairs and mean drift zero, no output pending.
module clock_drift_time_sync #(
	parameter int TIME_BITS = cdts_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_we,
	input  logic [cdts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cdts_pkg::TPS_W-1:0]       cfg_data,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [cdts_pkg::KIND_W-1:0]      kind,
	input  logic [TIME_BITS-1:0]             local_time,
	input  logic [TIME_BITS-1:0]             master_time,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [TIME_BITS-1:0]             converted_time,
	output logic [cdts_pkg::STATUS_W-1:0]    status,
	output logic signed [cdts_pkg::MEAS_W-1:0] measured_drift,
	output logic signed [cdts_pkg::AVG_W-1:0]   mean_drift
);
	import cdts_pkg::*;

	// ---------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------
	state_t                     state_q;
	step_t                      step_q;
	logic [CNT_W-1:0]           cnt_q;

	// configuration
	logic [TPS_W-1:0]           tps_q;
	logic [DRIFT_W-1:0]         max_q;
	logic [DRIFT_W-1:0]         typ_q;

	// sync state
	logic [TIME_BITS-1:0]       captured_q;
	logic                       pend_q;
	logic [TIME_BITS-1:0]       sync_master_q;
	logic [TIME_BITS-1:0]       sync_local_q;
	logic [TIME_BITS-1:0]       prev_master_q;
	logic [TIME_BITS-1:0]       prev_local_q;
	logic signed [AVG_W-1:0]    avg_q;

	// held input transaction
	logic [KIND_W-1:0]          kind_q;
	logic [TIME_BITS-1:0]       lt_q;
	logic [TIME_BITS-1:0]       mt_q;

	// serial multiplier: acc += mcand << k for each set bit k of mplier, minus for the sign bit
	logic [ARITH_W-1:0]         acc_q;
	logic [ARITH_W-1:0]         mcand_q;
	logic [MUL_W-1:0]           mplier_q;

	// restoring divider: quo_q shifts dividend bits out and quotient bits in
	logic [ARITH_W-1:0]         rem_q;
	logic [ARITH_W-1:0]         quo_q;
	logic [ARITH_W-1:0]         dvs_q;
	logic                       neg_q;

	logic [ARITH_W-1:0]         m_q;     // signed master interval of this set

	// result waiting for the output register
	logic [TIME_BITS-1:0]       res_conv_q;
	status_t                    res_status_q;
	logic [MEAS_W-1:0]          res_meas_q;

	logic                       out_valid_q;
	logic [TIME_BITS-1:0]       conv_q;
	logic [STATUS_W-1:0]        status_q;
	logic [MEAS_W-1:0]          meas_q;
	logic [AVG_W-1:0]           mean_q;

	// ---------------------------------------------------------------------
	// Handshake
	// ---------------------------------------------------------------------
	logic in_fire;
	logic out_free;
	logic fin_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign fin_load  = (state_q == ST_FIN) && out_free;

	assign out_valid      = out_valid_q;
	assign converted_time = conv_q;
	assign status         = status_q;
	assign measured_drift = $signed(meas_q);
	assign mean_drift     = $signed(mean_q);

	// ---------------------------------------------------------------------
	// Item decode (EVAL): interval and tick differences, wrapped to TIME_BITS
	// ---------------------------------------------------------------------
	logic [TIME_BITS-1:0]       master_span;
	logic [TIME_BITS-1:0]       tick_span;
	logic [TIME_BITS-1:0]       query_span;
	logic [ARITH_W-1:0]         master_sext;
	logic [ARITH_W-1:0]         query_sext;
	logic signed [MUL_W-1:0]    factor;
	status_t                    eval_status;

	assign master_span = mt_q - prev_master_q;
	assign tick_span   = captured_q - prev_local_q;
	assign query_span  = lt_q - sync_local_q;
	assign master_sext = ARITH_W'($signed(master_span));
	assign query_sext  = ARITH_W'($signed(query_span));
	// 1e6 - avg; negative only if the average was clamped above one million
	assign factor      = US_MUL - MUL_W'(avg_q);

	always_comb begin
		eval_status = STAT_OK;
		unique case (kind_q)
			KIND_CAPTURE: begin
				if (pend_q)
					eval_status = STAT_CAP_IGN;
			end
			KIND_SET: begin
				if (!pend_q)
					eval_status = STAT_NO_CAP;
				else if (prev_master_q == '0)
					eval_status = STAT_FIRST;
				else if (master_span == '0)
					eval_status = STAT_ZERO_INT;
			end
			default: eval_status = STAT_OK;
		endcase
	end

	// set needs the drift computation only for a real, nonzero interval
	logic eval_drift;
	assign eval_drift = (kind_q == KIND_SET) && pend_q && (prev_master_q != '0)
		&& (master_span != '0);

	// ---------------------------------------------------------------------
	// Multiplier step: bit MUL_W-1 of the multiplier is the sign bit, so the
	// last step subtracts.
	// ---------------------------------------------------------------------
	logic [ARITH_W-1:0] mul_sum;
	assign mul_sum = (cnt_q == '0) ? (acc_q - mcand_q) : (acc_q + mcand_q);

	// ---------------------------------------------------------------------
	// Operand signs for the divider (SIGN state)
	// ---------------------------------------------------------------------
	logic               prod_neg;
	logic [ARITH_W-1:0] prod_abs;
	logic [ARITH_W-1:0] m_abs;
	logic [ARITH_W-1:0] tps_div;
	logic [ARITH_W-1:0] div_a;
	logic [ARITH_W-1:0] div_b;
	logic               div_neg;

	assign prod_neg = acc_q[ARITH_W-1];
	assign prod_abs = prod_neg ? (ARITH_W'(0) - acc_q) : acc_q;
	assign m_abs    = m_q[ARITH_W-1] ? (ARITH_W'(0) - m_q) : m_q;
	// zero ticks per second divides as one
	assign tps_div  = (tps_q == '0) ? ARITH_W'(1) : ARITH_W'(tps_q);

	always_comb begin
		unique case (step_q)
			STEP_L: begin
				div_a   = acc_q;
				div_b   = tps_div;
				div_neg = 1'b0;
			end
			STEP_X: begin
				div_a   = prod_abs;
				div_b   = m_abs;
				div_neg = prod_neg ^ m_q[ARITH_W-1];
			end
			default: begin
				div_a   = prod_abs;
				div_b   = tps_div;
				div_neg = prod_neg;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Divider step
	// ---------------------------------------------------------------------
	logic [ARITH_W+1:0] div_diff;
	logic               div_ge;
	logic [ARITH_W-1:0] div_rem;

	assign div_diff = {1'b0, rem_q, quo_q[ARITH_W-1]} - {2'b00, dvs_q};
	assign div_ge   = !div_diff[ARITH_W+1];
	assign div_rem  = div_ge ? div_diff[ARITH_W-1:0]
		: {rem_q[ARITH_W-2:0], quo_q[ARITH_W-1]};

	// ---------------------------------------------------------------------
	// Drift check and running average (APPLY of the drift pass)
	// ---------------------------------------------------------------------
	logic signed [MEAS_W:0]  d_ext;
	logic signed [MEAS_W:0]  mx_ext;
	logic signed [MEAS_W:0]  ty_ext;
	logic                    drift_ok;
	logic                    drift_unusual;
	logic signed [AVG_W-1:0] d_avg;
	logic signed [AVG_W:0]   avg_sum;
	logic signed [AVG_W:0]   avg_rnd;
	logic signed [AVG_W-1:0] avg_half;
	logic signed [AVG_W-1:0] avg_pre;
	logic signed [AVG_W-1:0] mx_avg;
	logic signed [AVG_W-1:0] avg_next;

	assign d_ext         = (MEAS_W+1)'($signed(quo_q[MEAS_W-1:0]));
	assign mx_ext        = $signed((MEAS_W+1)'(max_q));
	assign ty_ext        = $signed((MEAS_W+1)'(typ_q));
	assign drift_ok      = (d_ext < mx_ext) && (d_ext > -mx_ext);
	assign drift_unusual = (d_ext > ty_ext) || (d_ext < -ty_ext);

	// an accepted drift is below 2^20 in magnitude and fits the average width
	assign d_avg    = $signed(quo_q[AVG_W-1:0]);
	assign avg_sum  = (AVG_W+1)'(avg_q) + (AVG_W+1)'(d_avg);
	// halve toward zero: add one before the shift when negative
	assign avg_rnd  = avg_sum + (AVG_W+1)'(avg_sum[AVG_W]);
	assign avg_half = $signed(avg_rnd[AVG_W:1]);
	assign avg_pre  = (avg_q == '0) ? d_avg : avg_half;
	assign mx_avg   = $signed(AVG_W'(max_q));

	always_comb begin
		priority if (avg_pre > mx_avg)
			avg_next = mx_avg;
		else if (avg_pre < -mx_avg)
			avg_next = -mx_avg;
		else
			avg_next = avg_pre;
	end

	// ---------------------------------------------------------------------
	// Control, configuration and sync state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= STEP_L;
			cnt_q         <= '0;
			tps_q         <= TPS_RST;
			max_q         <= MAX_RST;
			typ_q         <= TYP_RST;
			captured_q    <= '0;
			pend_q        <= 1'b0;
			sync_master_q <= '0;
			sync_local_q  <= '0;
			prev_master_q <= '0;
			prev_local_q  <= '0;
			avg_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TPS: tps_q <= cfg_data;
					CFG_MAX: max_q <= cfg_data[DRIFT_W-1:0];
					CFG_TYP: typ_q <= cfg_data[DRIFT_W-1:0];
					default: ;
				endcase
			end

			out_valid_q <= fin_load || (out_valid_q && out_stall);

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_FIN;
					unique case (kind_q)
						KIND_CAPTURE: begin
							// the tick before the edge is the capture point
							if (!pend_q) begin
								captured_q <= lt_q - TIME_BITS'(1);
								pend_q     <= 1'b1;
							end
						end
						KIND_SET: begin
							if (pend_q) begin
								// the new pair becomes the previous pair at once;
								// m_q and tick_span carry what the drift needs
								sync_master_q <= mt_q;
								sync_local_q  <= captured_q;
								prev_master_q <= mt_q;
								prev_local_q  <= captured_q;
								pend_q        <= 1'b0;
							end
							if (eval_drift) begin
								step_q  <= STEP_L;
								cnt_q   <= CNT_W'(MUL_W-1);
								state_q <= ST_MUL;
							end
						end
						default: begin
							step_q  <= STEP_Q;
							cnt_q   <= CNT_W'(MUL_W-1);
							state_q <= ST_MUL;
						end
					endcase
				end
				ST_MUL: begin
					if (cnt_q == '0)
						state_q <= ST_SIGN;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				ST_SIGN: begin
					cnt_q   <= CNT_W'(ARITH_W-1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_POST;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				ST_POST: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					unique case (step_q)
						STEP_L: begin
							step_q  <= STEP_X;
							cnt_q   <= CNT_W'(MUL_W-1);
							state_q <= ST_MUL;
						end
						STEP_X: begin
							if (drift_ok)
								avg_q <= avg_next;
							state_q <= ST_FIN;
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					kind_q <= kind;
					lt_q   <= local_time;
					mt_q   <= master_time;
				end
			end
			ST_EVAL: begin
				res_conv_q   <= '0;
				res_meas_q   <= '0;
				res_status_q <= eval_status;
				acc_q        <= '0;
				m_q          <= master_sext;
				if (kind_q == KIND_SET) begin
					mcand_q  <= ARITH_W'(tick_span);
					mplier_q <= US_MUL;
				end else begin
					mcand_q  <= query_sext;
					mplier_q <= factor;
				end
			end
			ST_MUL: begin
				if (mplier_q[0])
					acc_q <= mul_sum;
				mcand_q  <= {mcand_q[ARITH_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[MUL_W-1:1]};
			end
			ST_SIGN: begin
				rem_q <= '0;
				quo_q <= div_a;
				dvs_q <= div_b;
				neg_q <= div_neg;
			end
			ST_DIV: begin
				rem_q <= div_rem;
				quo_q <= {quo_q[ARITH_W-2:0], div_ge};
			end
			ST_POST: begin
				if (neg_q)
					quo_q <= ARITH_W'(0) - quo_q;
			end
			ST_APPLY: begin
				unique case (step_q)
					STEP_L: begin
						// quo_q holds the local interval in microseconds
						acc_q    <= '0;
						mcand_q  <= quo_q - m_q;
						mplier_q <= US_MUL;
					end
					STEP_X: begin
						res_meas_q <= quo_q[MEAS_W-1:0];
						if (!drift_ok)
							res_status_q <= STAT_REJECT;
						else if (drift_unusual)
							res_status_q <= STAT_UNUSUAL;
						else
							res_status_q <= STAT_OK;
					end
					default: begin
						res_conv_q <= sync_master_q + quo_q[TIME_BITS-1:0];
					end
				endcase
			end
			ST_FIN: begin
				if (out_free) begin
					conv_q   <= res_conv_q;
					status_q <= res_status_q;
					meas_q   <= res_meas_q;
					mean_q   <= avg_q;
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dvs_q != '0))
		else $error("divider running with a zero divisor");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("finished result not presented");

	a_avg_only_drift: assert property (@(posedge clk) disable iff (!arst_n)
		!((state_q == ST_APPLY) && (step_q == STEP_X)) |=> $stable(avg_q))
		else $error("mean drift changed outside a drift update");

	a_pend_only_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EVAL) |=> $stable(pend_q))
		else $error("capture flag changed outside item decode");

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_EVAL))
		else $error("accepted transaction not decoded");

endmodule
